// File: rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256 package
// shared types, round constants and round functions for the sha-256 core
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  // queue entry between byte front end and compression back end
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } byte_cmd_t;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd56;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// File: rtl/core/sha256_if.sv
// ----------------------------------------------------------------------------
// sha256 channel interfaces
// valid/ready channels for message bytes and digest words
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: rtl/core/sha256_fifo.sv
// ----------------------------------------------------------------------------
// sha256 byte queue
// short queue decoupling byte intake from block compression
// ----------------------------------------------------------------------------
module sha256_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sha256_pkg::byte_cmd_t push_data,
  output logic                  full,
  input  logic                  pop,
  output sha256_pkg::byte_cmd_t pop_data,
  output logic                  empty
);

  sha256_pkg::byte_cmd_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full     = (count == 3'd4);
  assign empty    = (count == 3'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'd0, push && !full} - {2'd0, pop && !empty};
    end
  end

endmodule

// File: rtl/core/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256 compression back end
// packs bytes into the schedule window, pads, runs 64 rounds, emits digest
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_empty,
  input  sha256_pkg::byte_cmd_t cmd,
  output logic                  cmd_pop,
  sha256_out_if.source          out_ch
);

  typedef enum logic [5:0] {
    S_BYTE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_ROUND = 6'b000100,
    S_ADD   = 6'b001000,
    S_OUT   = 6'b010000,
    S_IDLE2 = 6'b100000
  } state_t;

  state_t state;
  sha256_pkg::word_t w [16];
  sha256_pkg::word_t h [8];
  sha256_pkg::word_t a, b, c, d, e, f, g, hh;
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic [5:0]  round;
  logic        closing;
  logic        len_done;
  logic [2:0]  out_idx;
  logic        byte_go;

  sha256_pkg::word_t t1, t2, w_new;
  logic [1:0] lane;

  assign lane  = fill[1:0];
  assign t1    = hh + sha256_pkg::bsig1(e) + ((e & f) ^ (~e & g))
               + sha256_pkg::ROUND_K[round] + w[0];
  assign t2    = sha256_pkg::bsig0(a) + ((a & b) ^ (a & c) ^ (b & c));
  assign w_new = sha256_pkg::ssig1(w[14]) + w[9] + sha256_pkg::ssig0(w[1]) + w[0];

  assign byte_go = (state == S_BYTE) && !cmd_empty;
  assign cmd_pop = byte_go;

  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.digest_word = h[out_idx];
  assign out_ch.word_index  = out_idx;
  assign out_ch.last_word   = (out_idx == 3'd7);

  // put one byte into the word window at the fill position
  function automatic sha256_pkg::word_t put_byte(input sha256_pkg::word_t x,
                                                 input logic [1:0] pos,
                                                 input logic [7:0] v);
    sha256_pkg::word_t r;
    r = x;
    case (pos)
      2'd0:    r[31:24] = v;
      2'd1:    r[23:16] = v;
      2'd2:    r[15:8]  = v;
      default: r[7:0]   = v;
    endcase
    return r;
  endfunction

  // pad byte at the fill position, zero below it
  function automatic sha256_pkg::word_t pad_word(input sha256_pkg::word_t x,
                                                 input logic [1:0] pos);
    sha256_pkg::word_t r;
    case (pos)
      2'd0:    r = {sha256_pkg::PAD_BYTE, 24'd0};
      2'd1:    r = {x[31:24], sha256_pkg::PAD_BYTE, 16'd0};
      2'd2:    r = {x[31:16], sha256_pkg::PAD_BYTE, 8'd0};
      default: r = {x[31:8], sha256_pkg::PAD_BYTE};
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_BYTE;
      fill       <= '0;
      bit_length <= '0;
      closing    <= 1'b0;
      len_done   <= 1'b0;
      out_idx    <= '0;
      round      <= '0;
      for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::INIT_HASH[i];
    end else begin
      unique case (state)
        S_BYTE: begin
          if (byte_go) begin
            if (cmd.present) begin
              w[fill[5:2]] <= put_byte(w[fill[5:2]], lane, cmd.data);
              fill       <= fill + 6'd1;
              bit_length <= bit_length + 64'd8;
            end
            closing <= cmd.last;
            if (cmd.present && fill == 6'd63) begin
              state <= S_ROUND;
              round <= '0;
              {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
            end else if (cmd.last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // pad byte then zero fill, then length or an extra block
          if (!len_done) begin
            w[fill[5:2]] <= pad_word(w[fill[5:2]], lane);
            for (int i = 0; i < 16; i++) begin
              if (i > int'(fill[5:2])) w[i] <= '0;
            end
            len_done <= 1'b1;
            if (fill >= sha256_pkg::LEN_SLOT) begin
              state <= S_IDLE2;
            end
          end else begin
            w[14] <= bit_length[63:32];
            w[15] <= bit_length[31:0];
            state <= S_IDLE2;
          end
        end
        S_IDLE2: begin
          round <= '0;
          {a, b, c, d, e, f, g, hh} <= {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
          state <= S_ROUND;
        end
        S_ROUND: begin
          hh <= g; g <= f; f <= e; e <= d + t1;
          d <= c; c <= b; b <= a; a <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
          w[15] <= w_new;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c; h[3] <= h[3] + d;
          h[4] <= h[4] + e; h[5] <= h[5] + f; h[6] <= h[6] + g; h[7] <= h[7] + hh;
          fill <= '0;
          if (!closing) begin
            state <= S_BYTE;
          end else if (len_done && fill >= sha256_pkg::LEN_SLOT) begin
            // extra block case: after the pad-only block, length goes into a zero block
            for (int i = 0; i < 14; i++) w[i] <= '0;
            w[14] <= bit_length[63:32];
            w[15] <= bit_length[31:0];
            state <= S_IDLE2;
          end else if (len_done) begin
            state   <= S_OUT;
            out_idx <= '0;
          end else begin
            // full block ended exactly on the closing byte
            for (int i = 0; i < 16; i++) w[i] <= '0;
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              state      <= S_BYTE;
              fill       <= '0;
              bit_length <= '0;
              closing    <= 1'b0;
              len_done   <= 1'b0;
              for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::INIT_HASH[i];
            end
          end
        end
        default: state <= S_BYTE;
      endcase
    end
  end

endmodule

// File: rtl/core/sha256_message_digest.sv
// ----------------------------------------------------------------------------
// sha-256 message digest
// byte-wide message intake, sha-256 padding and compression, digest output
// ----------------------------------------------------------------------------
// in_ch carries one transaction per item: a message byte (when byte_present
// is set) and an end_of_message flag that closes the message. out_ch returns
// the eight digest words, word_index 0 first, last_word on the eighth.
// a four-entry queue parts the intake from the compression engine, so bytes
// keep arriving while a block is hashed, until the queue fills.
// the engine takes a byte whenever it is collecting and the queue holds one;
// a full data block then runs 64 rounds in one shared round unit and one
// chaining add, the load riding on the last byte.
// closing a message runs the padding state, then one or two block passes
// (load, 64 rounds, add), then eight output transactions.
// when the receiver stalls, the engine holds the current digest word and
// stops draining the queue; intake stalls once the queue is full.
// synchronous reset returns the chaining words to the sha-256 initial value
// and clears fill, length and the queue; after each digest the chaining words,
// fill and length are restored the same way for the next message.
// ----------------------------------------------------------------------------
module sha256_message_digest (
  input  logic        clk,
  input  logic        rst,
  sha256_in_if.sink   in_ch,
  sha256_out_if.source out_ch
);

  sha256_pkg::byte_cmd_t push_cmd;
  sha256_pkg::byte_cmd_t pop_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // items with neither flag set do nothing, so they never enter the queue
  assign in_ch.ready = !q_full;
  assign push_cmd    = '{data: in_ch.data_byte, present: in_ch.byte_present,
                         last: in_ch.end_of_message};

  sha256_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_ch.valid && (in_ch.byte_present || in_ch.end_of_message)),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .empty     (q_empty)
  );

  sha256_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_empty),
    .cmd       (pop_cmd),
    .cmd_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/core/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256 port checker
// port-level checks on digest sequencing and stall behaviour
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word mismatch");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=> (out_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest words not consecutive");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(digest_word) && $stable(word_index)))
    else $error("stalled word changed");

  a_first: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (word_index == 3'd0))
    else $error("digest did not start at word 0");

endmodule

bind sha256_message_digest sha256_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .digest_word (out_ch.digest_word),
  .word_index  (out_ch.word_index),
  .last_word   (out_ch.last_word)
);
